// ===== hdl/gle_pkg.sv =====
// Shared constants and types for the Golomb encoder.
// Used by gle_div, gle_pack and golomb_encoder; depends on nothing.
package gle_pkg;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int MAX_UNARY = 1023;
  localparam int UNARY_W   = 10;
  localparam int CHUNK_W   = 32;
  localparam int CHUNK_LOG = $clog2(CHUNK_W);
  localparam int BITS_W    = 6;
  localparam int TOTAL_W   = 11;
  localparam int NB_W      = 5;
  localparam int SFX_W     = DIV_W + 1;
  localparam int SFX_CNT_W = 5;
  localparam int ZCNT_W    = UNARY_W - CHUNK_LOG;

  // Reset value of the divisor and its derived terms
  localparam logic [DIV_W-1:0] DIVISOR_RST = DIV_W'(4);
  localparam logic [NB_W-1:0]  WIDTH_RST   = NB_W'(2);

  // One codeword job handed from the front end to the packer
  typedef struct packed {
    logic               ovf;
    logic [UNARY_W-1:0] quot;
    logic [NB_W-1:0]    nb;
    logic [DIV_W-1:0]   val;
    logic [TOTAL_W-1:0] total;
  } gle_job_t;

endpackage

// ===== hdl/gle_div.sv =====
// Zigzag fold and bit-serial restoring divider, one quotient bit per cycle.
// Depends on gle_pkg.
module gle_div import gle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [DIV_W-1:0]    divisor_i,
  output logic                done_o,
  output logic [DIV_W-1:0]    quot_o,
  output logic [DIV_W-1:0]    rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     folded;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;

  // Fold: n >= 0 maps to 2n, n < 0 maps to -2n-1
  assign folded = {sample_i[SAMPLE_W-2:0], 1'b0} ^ {DIV_W{sample_i[SAMPLE_W-1]}};

  // One restoring step: shift in a dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W - 1);
      dvd_d  = folded;
      rem_d  = '0;
    end else if (busy_q) begin
      if (!diff[DIV_W]) begin
        rem_d = diff[DIV_W-1:0];
        dvd_d = {dvd_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_W-1:0];
        dvd_d = {dvd_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/gle_pack.sv =====
// Codeword packer: an overflow word, or whole zero words for the unary run, then the
// terminating one and remainder, one bit per unstalled cycle. Depends on gle_pkg.
module gle_pack import gle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  gle_job_t           job_i,
  output logic               done_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHUNK_W-1:0] code_chunk_o,
  output logic [BITS_W-1:0]  chunk_bits_o,
  output logic [TOTAL_W-1:0] total_bits_o,
  output logic               overflow_o,
  output logic               last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_SFX  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [ZCNT_W-1:0]    zcnt_q, zcnt_d;
  logic [SFX_CNT_W-1:0] left_q, left_d;
  logic [BITS_W-1:0]    cnt_q, cnt_d;
  logic [CHUNK_W-1:0]   acc_q, acc_d;
  logic [SFX_W-1:0]     sfx_q, sfx_d;
  logic [TOTAL_W-1:0]   total_q, total_d;

  logic                 ovalid_q, ovalid_d;
  logic [CHUNK_W-1:0]   ochunk_q, ochunk_d;
  logic [BITS_W-1:0]    obits_q, obits_d;
  logic [TOTAL_W-1:0]   ototal_q, ototal_d;
  logic                 oovf_q, oovf_d;
  logic                 olast_q, olast_d;

  logic                 out_free;
  logic                 load;
  logic                 fin;
  logic [SFX_W-1:0]     sfx_raw;
  logic [SFX_W-1:0]     sfx_align;
  logic [CHUNK_W-1:0]   acc_new;
  logic [BITS_W-1:0]    cnt_new;

  assign out_free = !ovalid_q || !out_stall_i;

  // Suffix: a one followed by nb remainder bits, left-aligned for MSB-first shifting
  assign sfx_raw   = SFX_W'(job_i.val) | (SFX_W'(1) << job_i.nb);
  assign sfx_align = sfx_raw << (NB_W'(SFX_W - 1) - job_i.nb);

  assign acc_new = {acc_q[CHUNK_W-2:0], sfx_q[SFX_W-1]};
  assign cnt_new = cnt_q + BITS_W'(1);

  always_comb begin
    state_d  = state_q;
    zcnt_d   = zcnt_q;
    left_d   = left_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    sfx_d    = sfx_q;
    total_d  = total_q;
    load     = 1'b0;
    fin      = 1'b0;
    ochunk_d = ochunk_q;
    obits_d  = obits_q;
    ototal_d = ototal_q;
    oovf_d   = oovf_q;
    olast_d  = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          // Leading zeros of the last partial word stay implicit in acc
          zcnt_d  = job_i.quot[UNARY_W-1:CHUNK_LOG];
          cnt_d   = BITS_W'(job_i.quot[CHUNK_LOG-1:0]);
          acc_d   = '0;
          sfx_d   = sfx_align;
          left_d  = SFX_CNT_W'(job_i.nb) + SFX_CNT_W'(1);
          total_d = job_i.total;
          if (job_i.ovf) begin
            state_d = ST_OVF;
          end else if (job_i.quot[UNARY_W-1:CHUNK_LOG] != '0) begin
            state_d = ST_ZERO;
          end else begin
            state_d = ST_SFX;
          end
        end
      end
      ST_OVF: begin
        if (out_free) begin
          load     = 1'b1;
          fin      = 1'b1;
          ochunk_d = '0;
          obits_d  = '0;
          ototal_d = '0;
          oovf_d   = 1'b1;
          olast_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_ZERO: begin
        // Emit one full word of the unary run
        if (out_free) begin
          load     = 1'b1;
          ochunk_d = '0;
          obits_d  = BITS_W'(CHUNK_W);
          ototal_d = '0;
          oovf_d   = 1'b0;
          olast_d  = 1'b0;
          zcnt_d   = zcnt_q - ZCNT_W'(1);
          if (zcnt_q == ZCNT_W'(1)) begin
            state_d = ST_SFX;
          end
        end
      end
      ST_SFX: begin
        // Shift one suffix bit into the word under construction
        if (out_free) begin
          sfx_d  = {sfx_q[SFX_W-2:0], 1'b0};
          left_d = left_q - SFX_CNT_W'(1);
          if (left_q == SFX_CNT_W'(1)) begin
            load     = 1'b1;
            fin      = 1'b1;
            ochunk_d = acc_new;
            obits_d  = cnt_new;
            ototal_d = total_q;
            oovf_d   = 1'b0;
            olast_d  = 1'b1;
            state_d  = ST_IDLE;
          end else if (cnt_new == BITS_W'(CHUNK_W)) begin
            load     = 1'b1;
            ochunk_d = acc_new;
            obits_d  = cnt_new;
            ototal_d = '0;
            oovf_d   = 1'b0;
            olast_d  = 1'b0;
            acc_d    = '0;
            cnt_d    = '0;
          end else begin
            acc_d = acc_new;
            cnt_d = cnt_new;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output word register: hold while stalled, drop once taken
  always_comb begin
    ovalid_d = ovalid_q;
    if (out_free) begin
      ovalid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zcnt_q   <= zcnt_d;
    left_q   <= left_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    sfx_q    <= sfx_d;
    total_q  <= total_d;
    ochunk_q <= ochunk_d;
    obits_q  <= obits_d;
    ototal_q <= ototal_d;
    oovf_q   <= oovf_d;
    olast_q  <= olast_d;
  end

  assign done_o       = fin;
  assign out_valid_o  = ovalid_q;
  assign code_chunk_o = ochunk_q;
  assign chunk_bits_o = obits_q;
  assign total_bits_o = ototal_q;
  assign overflow_o   = oovf_q;
  assign last_o       = olast_q;

endmodule

// ===== hdl/golomb_encoder.sv =====
// Golomb encoder top level: divisor register, remainder coding and control.
// Depends on gle_pkg, gle_div and gle_pack.
//
// Usage:
//   Input channel: sample_i with in_valid_i / in_stall_o. One signed sample
//   is taken per codeword; the block then stalls input until the codeword is
//   fully handed to the output register.
//   Output channel: code_chunk_o, chunk_bits_o, total_bits_o, overflow_o and
//   last_o with out_valid_o / out_stall_i. A codeword leaves as one or more
//   words of up to 32 bits, right-aligned, last_o and total_bits_o on the
//   final one. A quotient above 1023 gives a single word with overflow_o.
//   Configuration: cfg_we_i writes cfg_wdata_i as the divisor (0 acts as 1).
//   Write it only while the block is idle.
// Operation: each item passes through the bit-serial divider, then the packer,
//   which emits full zero words of the unary part one word per cycle and then
//   shifts in the terminating one and the remainder bit by bit, both only
//   while the output is not stalled. An item whose quotient overflows skips
//   both and ends in the overflow word.
// Reset: clears all control and sets the divisor to 4. A stalled receiver
//   holds the output word and pauses the packer in place.
module golomb_encoder import gle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [DIV_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CHUNK_W-1:0]  code_chunk_o,
  output logic [BITS_W-1:0]   chunk_bits_o,
  output logic [TOTAL_W-1:0]  total_bits_o,
  output logic                overflow_o,
  output logic                last_o
);

  logic [DIV_W-1:0] div_q, div_d;
  logic [NB_W-1:0]  width_q, width_d;
  logic [DIV_W-1:0] xoff_q, xoff_d;
  logic             busy_q, busy_d;

  logic [DIV_W-1:0] m_eff;
  logic [DIV_W-1:0] m_less;
  logic             accept;
  logic             div_done;
  logic [DIV_W-1:0] quot;
  logic [DIV_W-1:0] rem;
  logic             pack_done;
  logic             short_code;
  gle_job_t         job;

  // Derive divisor, remainder width b and truncation offset 2^b - m on write
  always_comb begin
    m_eff   = (cfg_wdata_i == '0) ? DIV_W'(1) : cfg_wdata_i;
    m_less  = m_eff - DIV_W'(1);
    width_d = '0;
    for (int i = 0; i < DIV_W; i++) begin
      if (m_less[i]) begin
        width_d = NB_W'(i + 1);
      end
    end
    xoff_d = DIV_W'((SFX_W'(1) << width_d) - SFX_W'(m_eff));
    div_d  = m_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= DIVISOR_RST;
      width_q <= WIDTH_RST;
      xoff_q  <= '0;
    end else if (cfg_we_i) begin
      div_q   <= div_d;
      width_q <= width_d;
      xoff_q  <= xoff_d;
    end
  end

  // Hold input off from acceptance until the packer has issued the last word
  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (pack_done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  gle_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .sample_i  (sample_i),
    .divisor_i (div_q),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  // Truncated binary remainder: short form below the offset, else offset added
  always_comb begin
    short_code = rem < xoff_q;
    job.ovf    = quot > DIV_W'(MAX_UNARY);
    job.quot   = quot[UNARY_W-1:0];
    job.nb     = short_code ? (width_q - NB_W'(1)) : width_q;
    job.val    = short_code ? rem : (rem + xoff_q);
    job.total  = TOTAL_W'(quot[UNARY_W-1:0]) + TOTAL_W'(1) + TOTAL_W'(job.nb);
  end

  gle_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (div_done),
    .job_i        (job),
    .done_o       (pack_done),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_chunk_o (code_chunk_o),
    .chunk_bits_o (chunk_bits_o),
    .total_bits_o (total_bits_o),
    .overflow_o   (overflow_o),
    .last_o       (last_o)
  );

endmodule
